FILE: rtl/kdx_pkg.sv
// Shared types, character codes and base decoding for the k-mer stream extractor.
// No dependencies; imported by every rtl module of the block.
package kdx_pkg;

	localparam int LEN_W  = 6;   // word_length register width
	localparam int KMER_W = 64;  // kmer_word field width
	localparam int IDX_W  = 48;  // word_index field width
	localparam int DATA_W = KMER_W + IDX_W;

	localparam logic [7:0] CH_EOF  = 8'h00;
	localparam logic [7:0] CH_NL   = 8'h0a;
	localparam logic [7:0] CH_GT   = 8'h3e;
	localparam logic [7:0] CH_AT   = 8'h40;
	localparam logic [7:0] CH_PLUS = 8'h2b;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam logic [1:0] EV_WORD  = 2'd0;
	localparam logic [1:0] EV_START = 2'd1;
	localparam logic [1:0] EV_END   = 2'd2;
	localparam logic [1:0] EV_ERROR = 2'd3;

	localparam logic CFG_WORD_LENGTH = 1'b0;
	localparam logic CFG_CANONIZE    = 1'b1;

	typedef enum logic [3:0] {
		PH_START,
		PH_NAME,
		PH_SEQ,
		PH_PLUS,
		PH_PLUSNL,
		PH_QUAL,
		PH_QEND,
		PH_DONE,
		PH_ERROR
	} phase_t;

	// request from the parser to the k-mer window
	typedef struct packed {
		logic       clear;
		logic       shift;
		logic [1:0] code;
	} win_ctl_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [IDX_W-1:0]  index;
		logic [KMER_W-1:0] word;
	} res_t;

	// bit 2 set: not a base
	function automatic logic [2:0] base_code(input logic [7:0] b);
		logic [2:0] r;
		r = 3'b100;
		case (b)
			8'h41, 8'h61: r = 3'd0;
			8'h43, 8'h63: r = 3'd1;
			8'h47, 8'h67: r = 3'd2;
			8'h54, 8'h74, 8'h55, 8'h75: r = 3'd3;
			default: r = 3'b100;
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/kdx_parser.sv
// FASTA/FASTQ format state machine: decides window updates and event kinds per byte.
// Depends on kdx_pkg.
module kdx_parser import kdx_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] text_byte,
	input  logic       win_hit,
	output win_ctl_t   win_ctl,
	output logic       res_valid,
	output logic [1:0] res_kind
);

	phase_t     phase_q, phase_d;
	logic       fastq_q, fastq_d;
	logic [2:0] bc;
	logic       is_base;

	assign bc      = base_code(text_byte);
	assign is_base = ~bc[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			fastq_q <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			fastq_q <= fastq_d;
		end
	end

	// next state
	always_comb begin
		phase_d = phase_q;
		fastq_d = fastq_q;
		unique case (phase_q)
			PH_START: begin
				if (text_byte == CH_EOF) phase_d = PH_DONE;
				else if (text_byte == CH_GT) begin
					phase_d = PH_NAME;
					fastq_d = 1'b0;
				end else if (text_byte == CH_AT) begin
					phase_d = PH_NAME;
					fastq_d = 1'b1;
				end else phase_d = PH_ERROR;
			end
			PH_NAME: begin
				if (text_byte == CH_EOF) phase_d = PH_DONE;
				else if (text_byte == CH_NL) phase_d = PH_SEQ;
			end
			PH_SEQ: begin
				if (text_byte == CH_EOF) phase_d = PH_DONE;
				else if (!fastq_q && text_byte == CH_GT) phase_d = PH_NAME;
				else if (fastq_q && text_byte == CH_NL) phase_d = PH_PLUS;
			end
			PH_PLUS: phase_d = (text_byte == CH_PLUS) ? PH_PLUSNL : PH_ERROR;
			PH_PLUSNL: phase_d = (text_byte == CH_NL) ? PH_QUAL : PH_ERROR;
			PH_QUAL: begin
				if (text_byte == CH_EOF) phase_d = PH_DONE;
				else if (text_byte == CH_NL) phase_d = PH_QEND;
			end
			PH_QEND: begin
				if (text_byte == CH_EOF) phase_d = PH_DONE;
				else if (text_byte == CH_AT) phase_d = PH_NAME;
				else phase_d = PH_ERROR;
			end
			PH_DONE, PH_ERROR: phase_d = phase_q;
			default: phase_d = phase_q;
		endcase
	end

	// outputs
	always_comb begin
		win_ctl.clear = 1'b0;
		win_ctl.shift = 1'b0;
		win_ctl.code  = bc[1:0];
		res_valid     = 1'b0;
		res_kind      = EV_WORD;
		unique case (phase_q)
			PH_START: begin
				if (text_byte != CH_EOF && text_byte != CH_GT && text_byte != CH_AT) begin
					res_valid = 1'b1;
					res_kind  = EV_ERROR;
				end
			end
			PH_NAME: begin
				if (text_byte == CH_NL) begin
					win_ctl.clear = 1'b1;
					res_valid     = 1'b1;
					res_kind      = EV_START;
				end
			end
			PH_SEQ: begin
				if (text_byte == CH_EOF || (!fastq_q && text_byte == CH_GT)
						|| (fastq_q && text_byte == CH_NL)) begin
					res_valid = 1'b1;
					res_kind  = EV_END;
				end else if (is_base) begin
					win_ctl.shift = 1'b1;
					res_valid     = win_hit;
					res_kind      = EV_WORD;
				end else if (text_byte >= CH_SPACE) begin
					win_ctl.clear = 1'b1;
				end
			end
			PH_PLUS: begin
				if (text_byte != CH_PLUS) begin
					res_valid = 1'b1;
					res_kind  = EV_ERROR;
				end
			end
			PH_PLUSNL: begin
				if (text_byte != CH_NL) begin
					res_valid = 1'b1;
					res_kind  = EV_ERROR;
				end
			end
			PH_QEND: begin
				if (text_byte != CH_EOF && text_byte != CH_AT) begin
					res_valid = 1'b1;
					res_kind  = EV_ERROR;
				end
			end
			PH_QUAL, PH_DONE, PH_ERROR: res_valid = 1'b0;
			default: res_valid = 1'b0;
		endcase
	end

endmodule

FILE: rtl/kdx_window.sv
// K-mer window: forward and reverse-complement words, fill count and word counter.
// Depends on kdx_pkg.
module kdx_window import kdx_pkg::*; #(
	parameter int MAX_WORD_LENGTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  win_ctl_t          ctl,
	input  logic [LEN_W-1:0]  word_length,
	input  logic              canonize,
	output logic              hit,
	output logic [KMER_W-1:0] kmer,
	output logic [IDX_W-1:0]  count
);

	localparam int KW = 2 * MAX_WORD_LENGTH;

	logic [KW-1:0]    fwd_q, rev_q, fwd_d, rev_d, mask, rev_ins, sel;
	logic [KW+1:0]    fwd_cat;
	logic [LEN_W-1:0] fill_q, fill_d, k_eff;
	logic [LEN_W:0]   fill_inc, shamt;
	logic [1:0]       code_c;
	logic [IDX_W-1:0] count_q;

	always_comb begin
		if (word_length == '0) k_eff = LEN_W'(1);
		else if (word_length > LEN_W'(MAX_WORD_LENGTH)) k_eff = LEN_W'(MAX_WORD_LENGTH);
		else k_eff = word_length;
	end

	assign mask    = ~({KW{1'b1}} << {k_eff, 1'b0});
	assign fwd_cat = {fwd_q, ctl.code};
	assign fwd_d   = fwd_cat[KW-1:0] & mask;

	// complement base lands at the top of the k-base window
	assign code_c  = ~ctl.code;
	assign shamt   = {k_eff - LEN_W'(1), 1'b0};
	assign rev_ins = KW'(code_c) << shamt;
	assign rev_d   = canonize ? ((rev_q >> 2) | rev_ins) : rev_q;

	assign fill_inc = {1'b0, fill_q} + (LEN_W+1)'(1);
	assign fill_d   = (fill_inc > {1'b0, k_eff}) ? k_eff : fill_inc[LEN_W-1:0];
	assign hit      = (fill_d == k_eff);

	assign sel   = (!canonize || fwd_d < rev_d) ? fwd_d : rev_d;
	assign kmer  = KMER_W'(sel);
	assign count = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q   <= '0;
			rev_q   <= '0;
			fill_q  <= '0;
			count_q <= '0;
		end else if (step) begin
			if (ctl.clear) begin
				fwd_q  <= '0;
				rev_q  <= '0;
				fill_q <= '0;
			end else if (ctl.shift) begin
				fwd_q  <= fwd_d;
				rev_q  <= rev_d;
				fill_q <= fill_d;
				if (hit) count_q <= count_q + IDX_W'(1);
			end
		end
	end

endmodule

FILE: rtl/kdx_out_buf.sv
// Two-entry result buffer (output register plus skid) on the master stream side.
// Depends on kdx_pkg.
module kdx_out_buf import kdx_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  res_t res,
	output logic space,
	output logic out_valid,
	input  logic out_ready,
	output res_t out_res
);

	logic main_valid_q, skid_valid_q, take;
	res_t main_q, skid_q;

	assign take      = main_valid_q & out_ready;
	assign space     = ~skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_res   = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (take) begin
			if (skid_valid_q) skid_valid_q <= 1'b0;
			else main_valid_q <= push;
		end else if (push) begin
			if (main_valid_q) skid_valid_q <= 1'b1;
			else main_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (skid_valid_q) main_q <= skid_q;
			else if (push) main_q <= res;
		end else if (push) begin
			if (main_valid_q) skid_q <= res;
			else main_q <= res;
		end
	end

endmodule

FILE: rtl/dna_kmer_stream_extractor_top.sv
// Top level of the k-mer stream extractor: config registers, parser, window, result buffer.
// Depends on kdx_pkg, kdx_parser, kdx_window and kdx_out_buf.
//
// Usage:
//   s_axis carries one text byte per request of a FASTA or FASTQ stream; a 0 byte ends input.
//   m_axis carries at most one event per byte: k-mer word, sequence start, sequence end or
//   format error (tuser). tdata holds the k-mer and the running word index.
//   cfg writes word_length (index 0) and canonize (index 1); cfg_ready is always high.
//   Write configuration only while the block is idle.
// Timing:
//   One byte is taken every cycle while the skid entry is free, limited by the single
//   byte-wide parse step. Each byte is decoded and the window updated in the cycle it is
//   accepted; its event is registered into the output register or the skid entry behind it.
// Stall:
//   A skid entry behind the output register absorbs one more event; s_axis_tready drops
//   only while both are full, so no event is lost or repeated.
// Reset:
//   arst_n clears parse state, window, word counter and buffer; word_length returns to 16
//   and canonize to 0. The block is ready right after reset.
module dna_kmer_stream_extractor_top import kdx_pkg::*; #(
	parameter int MAX_WORD_LENGTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [7:0]        s_axis_tdata,   // [7:0] text_byte
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [DATA_W-1:0] m_axis_tdata,   // [63:0] kmer_word, [111:64] word_index
	output logic [1:0]        m_axis_tuser,   // [1:0] event_kind
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_index,
	input  logic [LEN_W-1:0]  cfg_data
);

	logic [LEN_W-1:0]  word_length_q;
	logic              canonize_q;
	logic              step, space, win_hit, res_valid;
	logic [1:0]        res_kind;
	logic [KMER_W-1:0] win_kmer;
	logic [IDX_W-1:0]  win_count;
	win_ctl_t          win_ctl;
	res_t              res, out_res;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = space;
	assign step          = s_axis_tvalid & space;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_length_q <= LEN_W'(16);
			canonize_q    <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_WORD_LENGTH: word_length_q <= cfg_data;
				CFG_CANONIZE:    canonize_q    <= cfg_data[0];
				default:         canonize_q    <= canonize_q;
			endcase
		end
	end

	kdx_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.text_byte (s_axis_tdata),
		.win_hit   (win_hit),
		.win_ctl   (win_ctl),
		.res_valid (res_valid),
		.res_kind  (res_kind)
	);

	kdx_window #(
		.MAX_WORD_LENGTH (MAX_WORD_LENGTH)
	) u_window (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.ctl         (win_ctl),
		.word_length (word_length_q),
		.canonize    (canonize_q),
		.hit         (win_hit),
		.kmer        (win_kmer),
		.count       (win_count)
	);

	assign res.kind  = res_kind;
	assign res.index = win_count;
	assign res.word  = (res_kind == EV_WORD) ? win_kmer : '0;

	kdx_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (step & res_valid),
		.res       (res),
		.space     (space),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (out_res)
	);

	assign m_axis_tdata = {out_res.index, out_res.word};
	assign m_axis_tuser = out_res.kind;

endmodule

FILE: dv/kmer_event_checker.sv
// Watches the byte, event and configuration channels of the k-mer stream extractor,
// predicts every event from its own parser model and compares them in order.
// Depends on kdx_pkg for field widths, character codes, event kinds and phases.
module kmer_event_checker import kdx_pkg::*; #(
	parameter int MAX_WORD_LENGTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	input  logic              s_axis_tready,
	input  logic [7:0]        s_axis_tdata,   // [7:0] text_byte
	input  logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	input  logic [DATA_W-1:0] m_axis_tdata,   // [63:0] kmer_word, [111:64] word_index
	input  logic [1:0]        m_axis_tuser,   // [1:0] event_kind
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic              cfg_index,
	input  logic [LEN_W-1:0]  cfg_data,
	output int                fail_count,
	output int                pending,
	output int                checked
);

	typedef struct packed {
		logic [1:0]        kind;
		logic [IDX_W-1:0]  index;
		logic [KMER_W-1:0] word;
	} kmer_event_t;

	kmer_event_t       event_q[$];

	logic [LEN_W-1:0]  word_len;
	logic              canon;
	phase_t            phase;
	logic              fastq;
	logic [KMER_W-1:0] fwd;
	logic [KMER_W-1:0] rev;
	logic [5:0]        fill;
	logic [IDX_W-1:0]  n_words;

	// 2-bit nucleotide, bit 2 set for anything else; folding to lower case is exact for these
	function automatic logic [2:0] nucleotide(input logic [7:0] b);
		case (b | 8'h20)
			"a": return 3'd0;
			"c": return 3'd1;
			"g": return 3'd2;
			"t", "u": return 3'd3;
			default: return 3'b100;
		endcase
	endfunction

	task automatic queue_event(input logic [1:0] kind, input logic [KMER_W-1:0] word);
		kmer_event_t e;
		e.kind = kind;
		e.index = n_words;
		e.word = word;
		event_q.push_back(e);
	endtask

	task automatic clear_window();
		fwd = '0;
		rev = '0;
		fill = '0;
	endtask

	task automatic parse_byte(input logic [7:0] b);
		logic [2:0]        n;
		logic [1:0]        comp;
		int                k;
		logic [KMER_W-1:0] mask;
		logic [KMER_W-1:0] w;
		k = (word_len == 0) ? 1 : (word_len > MAX_WORD_LENGTH) ? MAX_WORD_LENGTH : int'(word_len);
		if (k > 32) k = 32;
		case (phase)
			PH_START: begin
				if (b == CH_EOF) begin
					phase = PH_DONE;
				end else if (b == CH_GT) begin
					fastq = 1'b0;
					phase = PH_NAME;
				end else if (b == CH_AT) begin
					fastq = 1'b1;
					phase = PH_NAME;
				end else begin
					phase = PH_ERROR;
					queue_event(EV_ERROR, '0);
				end
			end
			PH_NAME: begin
				if (b == CH_EOF) begin
					phase = PH_DONE;
				end else if (b == CH_NL) begin
					phase = PH_SEQ;
					clear_window();
					queue_event(EV_START, '0);
				end
			end
			PH_SEQ: begin
				n = nucleotide(b);
				if (b == CH_EOF) begin
					phase = PH_DONE;
					queue_event(EV_END, '0);
				end else if (!fastq && b == CH_GT) begin
					phase = PH_NAME;
					queue_event(EV_END, '0);
				end else if (fastq && b == CH_NL) begin
					phase = PH_PLUS;
					queue_event(EV_END, '0);
				end else if (!n[2]) begin
					mask = (k >= 32) ? '1 : (64'd1 << (2 * k)) - 64'd1;
					fwd = ((fwd << 2) | {62'd0, n[1:0]}) & mask;
					if (canon) begin
						comp = ~n[1:0];
						rev = (rev >> 2) | ({62'd0, comp} << (2 * (k - 1)));
					end
					fill = fill + 6'd1;
					// fill saturates at the current length, also after a shorter length is set
					if (fill > k) fill = 6'(k);
					if (fill == k) begin
						w = (!canon || fwd < rev) ? fwd : rev;
						queue_event(EV_WORD, w);
						n_words = n_words + 1'b1;
					end
				end else if (b >= CH_SPACE) begin
					clear_window();
				end
			end
			PH_PLUS: begin
				if (b == CH_PLUS) begin
					phase = PH_PLUSNL;
				end else begin
					phase = PH_ERROR;
					queue_event(EV_ERROR, '0);
				end
			end
			PH_PLUSNL: begin
				if (b == CH_NL) begin
					phase = PH_QUAL;
				end else begin
					phase = PH_ERROR;
					queue_event(EV_ERROR, '0);
				end
			end
			PH_QUAL: begin
				if (b == CH_EOF) phase = PH_DONE;
				else if (b == CH_NL) phase = PH_QEND;
			end
			PH_QEND: begin
				if (b == CH_EOF) begin
					phase = PH_DONE;
				end else if (b == CH_AT) begin
					phase = PH_NAME;
				end else begin
					phase = PH_ERROR;
					queue_event(EV_ERROR, '0);
				end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		kmer_event_t       want;
		logic [KMER_W-1:0] got_word;
		logic [IDX_W-1:0]  got_index;
		if (!arst_n) begin
			event_q.delete();
			word_len = LEN_W'(16);
			canon = 1'b0;
			phase = PH_START;
			fastq = 1'b0;
			clear_window();
			n_words = '0;
			fail_count = 0;
			checked = 0;
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_WORD_LENGTH) word_len = cfg_data;
				else canon = cfg_data[0];
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got_word = m_axis_tdata[KMER_W-1:0];
				got_index = m_axis_tdata[KMER_W +: IDX_W];
				if (event_q.size() == 0) begin
					$display("%0t: unexpected event expected none got kind %0d word %h index %0d",
						$time, m_axis_tuser, got_word, got_index);
					fail_count++;
				end else begin
					want = event_q.pop_front();
					checked++;
					if (m_axis_tuser !== want.kind) begin
						$display("%0t: event_kind expected %0d got %0d", $time, want.kind, m_axis_tuser);
						fail_count++;
					end
					if (got_word !== want.word) begin
						$display("%0t: kmer_word expected %h got %h", $time, want.word, got_word);
						fail_count++;
					end
					if (got_index !== want.index) begin
						$display("%0t: word_index expected %0d got %0d", $time, want.index, got_index);
						fail_count++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) parse_byte(s_axis_tdata);
			pending = event_q.size();
		end
	end

endmodule

FILE: dv/tb_top.sv
// Stimulus and verdict for the k-mer stream extractor: FASTA or FASTQ text with config phases.
// Depends on kdx_pkg, dna_kmer_stream_extractor_top and kmer_event_checker.
module tb_top;
	import kdx_pkg::*;

	localparam int LIMIT      = 4000;
	localparam int IDLE_PCT   = 24;
	localparam int TEXT_BYTES = 1450;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [7:0]        s_axis_tdata = 8'h00;    // [7:0] text_byte
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [DATA_W-1:0] m_axis_tdata;            // [63:0] kmer_word, [111:64] word_index
	logic [1:0]        m_axis_tuser;            // [1:0] event_kind
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic              cfg_index = CFG_WORD_LENGTH;
	logic [LEN_W-1:0]  cfg_data = '0;

	int                fail_count;
	int                pending;
	int                checked;
	int                stall_cycles = 0;
	int                phases = 0;
	int                bytes_sent = 0;
	logic              quiet = 1'b0;
	logic              fastq_file;
	logic [7:0]        text_q[$];

	always #10 clk = ~clk;

	dna_kmer_stream_extractor_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	kmer_event_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.pending      (pending),
		.checked      (checked)
	);

	always @(posedge clk) m_axis_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
			(cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
		if (stall_cycles >= LIMIT) begin
			$display("dna_kmer_stream_extractor_top test failed");
			$finish;
		end
	end

	function automatic logic [7:0] base_char(input int i);
		case (i)
			0: return "A";
			1: return "C";
			2: return "G";
			3: return "T";
			4: return "U";
			5: return "a";
			6: return "c";
			7: return "g";
			8: return "t";
			default: return "u";
		endcase
	endfunction

	function automatic bit is_base_char(input logic [7:0] b);
		for (int i = 0; i < 10; i++) if (base_char(i) == b) return 1'b1;
		return 1'b0;
	endfunction

	// any byte but end of input and newline: header and quality text
	function automatic logic [7:0] line_byte();
		logic [7:0] b;
		b = 8'($urandom_range(255, 1));
		if (b == CH_NL) b = "h";
		return b;
	endfunction

	task automatic send_byte(input logic [7:0] b);
		while (!quiet && $urandom_range(99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		@(negedge clk);
		while (!s_axis_tready) @(negedge clk);
		@(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_byte(s[i]);
	endtask

	// drain all events, then wait out bytes that raise none
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_config(input logic [LEN_W-1:0] len, input logic canon);
		for (int r = 0; r < 2; r++) begin
			cfg_valid <= 1'b1;
			cfg_index <= (r == 0) ? CFG_WORD_LENGTH : CFG_CANONIZE;
			cfg_data <= (r == 0) ? len : {LEN_W'($urandom_range(31)) << 1} | LEN_W'(canon);
			@(negedge clk);
			while (!cfg_ready) @(negedge clk);
			@(posedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic add_bases(input logic fq);
		int         len;
		int         r;
		logic [7:0] b;
		len = ($urandom_range(3) == 0) ? $urandom_range(120) : $urandom_range(40);
		repeat (len) begin
			r = $urandom_range(99);
			if (r < 78) begin
				b = base_char($urandom_range(9));
			end else if (r < 85) begin
				b = 8'($urandom_range(8'h7e, 8'h20));
				if (is_base_char(b) || (!fq && b == CH_GT)) b = "N";
			end else if (r < 91) begin
				b = 8'($urandom_range(8'hff, 8'h7f));
			end else begin
				b = 8'($urandom_range(8'h1f, 8'h01));
				if (fq && b == CH_NL) b = 8'h09;
			end
			text_q.push_back(b);
		end
	endtask

	task automatic add_header(input logic fq);
		text_q.push_back(fq ? CH_AT : CH_GT);
		repeat ($urandom_range(5)) text_q.push_back(line_byte());
		text_q.push_back(CH_NL);
	endtask

	task automatic add_record(input logic fq);
		add_header(fq);
		add_bases(fq);
		if (fq) begin
			text_q.push_back(CH_NL);
			text_q.push_back(CH_PLUS);
			text_q.push_back(CH_NL);
			repeat ($urandom_range(8)) text_q.push_back(line_byte());
			text_q.push_back(CH_NL);
		end
	endtask

	// FASTA ends inside a sequence or a header, FASTQ after a quality line or in a last record
	task automatic add_ending(input logic fq);
		logic [7:0] b;
		int         pick;
		pick = $urandom_range(4);
		if (!fq) begin
			if (pick >= 2) begin
				text_q.push_back(CH_GT);
				if (pick == 3) repeat ($urandom_range(4)) text_q.push_back(line_byte());
			end
			text_q.push_back(CH_EOF);
		end else if (pick == 0) begin
			text_q.push_back(CH_EOF);
		end else if (pick == 1) begin
			b = 8'($urandom_range(255));
			if (b == CH_AT || b == CH_EOF) b = "+";
			text_q.push_back(b);
		end else begin
			add_header(fq);
			add_bases(fq);
			if (pick == 2) begin
				text_q.push_back(CH_EOF);
			end else begin
				text_q.push_back(CH_NL);
				if (pick == 3 && $urandom_range(1)) begin
					b = 8'($urandom_range(255));
					if (b == CH_PLUS) b = CH_EOF;
					text_q.push_back(b);
				end else begin
					text_q.push_back(CH_PLUS);
					if (pick == 3) begin
						b = 8'($urandom_range(255));
						if (b == CH_NL) b = "I";
						text_q.push_back(b);
					end else begin
						text_q.push_back(CH_NL);
						repeat ($urandom_range(4)) text_q.push_back(line_byte());
						text_q.push_back(CH_EOF);
					end
				end
			end
		end
		// ignored once parsing has stopped
		repeat (12) text_q.push_back(8'($urandom_range(255)));
	endtask

	task automatic next_config();
		logic [LEN_W-1:0] len;
		logic             canon;
		case (phases)
			0: begin len = 6'd32; canon = 1'b1; end
			1: begin len = 6'd1;  canon = 1'b0; end
			2: begin len = 6'd0;  canon = 1'b1; end
			3: begin len = 6'd63; canon = 1'b0; end
			4: begin len = 6'd16; canon = 1'b1; end
			5: begin len = 6'd2;  canon = 1'b0; end
			default: begin
				len = ($urandom_range(9) == 0) ? LEN_W'($urandom_range(63, 33))
					: LEN_W'($urandom_range(32, 1));
				canon = 1'($urandom_range(1));
			end
		endcase
		write_config(len, canon);
	endtask

	initial begin : stimulus
		logic [7:0] first;
		int         next_cut;
		fastq_file = 1'($urandom_range(1));
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset config first, then one-base canonical words and window clears
		first = fastq_file ? CH_AT : CH_GT;
		if ($urandom_range(15) == 0) begin
			first = 8'($urandom_range(255));
			if (first == CH_AT || first == CH_GT) first = "x";
		end
		send_byte(first);
		send_byte(CH_NL);
		send_text("ACGTUacgtuACGTAC");
		settle();
		write_config(6'd1, 1'b1);
		send_text("aCgTuN");
		send_byte(8'h01);
		send_byte(8'hff);
		send_byte("G");
		if (fastq_file) send_text("\n+\nI\n");

		while (text_q.size() < TEXT_BYTES) add_record(fastq_file);
		add_ending(fastq_file);
		next_cut = $urandom_range(160, 40);
		foreach (text_q[i]) begin
			if (i == next_cut) begin
				settle();
				next_config();
				phases++;
				quiet = (phases >= 5 && phases <= 7);
				next_cut += $urandom_range(160, 40);
			end
			send_byte(text_q[i]);
		end

		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (10) @(posedge clk);
		$display("%0d %s bytes sent across %0d configuration phases",
			bytes_sent, fastq_file ? "FASTQ" : "FASTA", phases);
		$display("%0d events compared, %0d mismatches", checked, fail_count);
		if (fail_count == 0) begin
			$display("dna_kmer_stream_extractor_top test passed");
		end else begin
			$display("dna_kmer_stream_extractor_top test failed");
		end
		$finish;
	end

endmodule

FILE: dna_kmer_stream_extractor_top.f
rtl/kdx_pkg.sv
rtl/kdx_parser.sv
rtl/kdx_window.sv
rtl/kdx_out_buf.sv
rtl/dna_kmer_stream_extractor_top.sv
dv/kmer_event_checker.sv
dv/tb_top.sv
